// File: rtl/srsw_pkg.sv
// shared types and codes for the selective repeat sender window
package srsw_pkg;

    localparam int SEQ_W = 32;
    localparam int LEN_W = 10;
    localparam int WL_W  = 3;

    localparam logic [WL_W-1:0] WL_RESET = 3'd4;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_NAK     = 2'd2,
        OP_TIMEOUT = 2'd3
    } op_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] length;
    } entry_t;

    typedef struct packed {
        logic             status;
        logic [SEQ_W-1:0] seq;
        logic [LEN_W-1:0] length;
        logic             last;
    } result_t;

endpackage

// File: rtl/srsw_mem.sv
// frame queue memory: one write port, one read port with registered read data
module srsw_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                aclk,
    input  logic                wr_en,
    input  logic [ADDR_W-1:0]   wr_addr,
    input  srsw_pkg::entry_t    wr_data,
    input  logic                rd_en,
    input  logic [ADDR_W-1:0]   rd_addr,
    output srsw_pkg::entry_t    rd_data
);

    srsw_pkg::entry_t mem [DEPTH];
    srsw_pkg::entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/srsw_out.sv
// output holding register for transmit requests
module srsw_out #(
    parameter int SLOT_W = 4
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  srsw_pkg::result_t            push_data,
    input  logic [SLOT_W-1:0]            push_slot,
    output logic                         free,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_status,
    output logic [SLOT_W-1:0]            m_tx_slot,
    output logic [srsw_pkg::SEQ_W-1:0]   m_tx_seq,
    output logic [srsw_pkg::LEN_W-1:0]   m_tx_length,
    output logic                         m_last
);

    logic              valid_reg;
    srsw_pkg::result_t data_reg;
    logic [SLOT_W-1:0] slot_reg;

    assign free = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= push_data;
            slot_reg <= push_slot;
        end
    end

    assign m_valid     = valid_reg;
    assign m_status    = data_reg.status;
    assign m_tx_slot   = slot_reg;
    assign m_tx_seq    = data_reg.seq;
    assign m_tx_length = data_reg.length;
    assign m_last      = data_reg.last;

endmodule

// File: rtl/srsw_ctrl.sv
// request sequencer: queue pointers, window search, ack release and refill
module srsw_ctrl #(
    parameter int WINDOW      = 4,
    parameter int QUEUE_DEPTH = 16,
    parameter int SLOT_W      = 4,
    parameter int CNT_W       = 5,
    parameter int IF_W        = 3
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [srsw_pkg::SEQ_W-1:0]   s_seq_number,
    input  logic [srsw_pkg::LEN_W-1:0]   s_frame_length,
    input  logic                         cfg_wr_en,
    input  logic [srsw_pkg::WL_W-1:0]    cfg_wr_data,
    output logic                         mem_wr_en,
    output logic [SLOT_W-1:0]            mem_wr_addr,
    output srsw_pkg::entry_t             mem_wr_data,
    output logic                         mem_rd_en,
    output logic [SLOT_W-1:0]            mem_rd_addr,
    input  srsw_pkg::entry_t             mem_rd_data,
    input  logic                         out_free,
    output logic                         out_push,
    output srsw_pkg::result_t            out_data,
    output logic [SLOT_W-1:0]            out_slot
);

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_SEND      = 7'b0000010,
        ST_SEARCH    = 7'b0000100,
        ST_RETX      = 7'b0001000,
        ST_ACK_UPD   = 7'b0010000,
        ST_FILL_RD   = 7'b0100000,
        ST_FILL_EMIT = 7'b1000000
    } state_t;

    state_t                       state_reg, state_next;
    srsw_pkg::op_t                op_reg, op_next;
    logic [srsw_pkg::SEQ_W-1:0]   seq_reg, seq_next;
    logic [srsw_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [SLOT_W-1:0]            head_reg, head_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [IF_W-1:0]              in_flight_reg, in_flight_next;
    logic [srsw_pkg::WL_W-1:0]    wl_reg;
    logic [IF_W-1:0]              pos_reg, pos_next;
    logic                         chk_valid_reg, chk_valid_next;
    logic [IF_W-1:0]              chk_pos_reg, chk_pos_next;
    logic [IF_W-1:0]              found_pos_reg, found_pos_next;
    logic [SLOT_W-1:0]            fill_slot_reg, fill_slot_next;

    logic [IF_W-1:0]              eff_w;
    logic [IF_W-1:0]              lim;
    logic                         can_send;
    logic                         fill_more;
    logic                         fill_last;
    logic                         queue_full;
    logic                         is_ack;
    logic [IF_W-1:0]              rel_if;
    logic [CNT_W-1:0]             rel_cnt;

    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
        if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
        end
        return sum[SLOT_W-1:0];
    endfunction

    // effective window and search bound
    always_comb begin
        if (wl_reg == '0) begin
            eff_w = IF_W'(1);
        end else if (32'(wl_reg) > WINDOW) begin
            eff_w = IF_W'(WINDOW);
        end else begin
            eff_w = IF_W'(wl_reg);
        end
        if (32'(count_reg) < 32'(eff_w)) begin
            lim = IF_W'(count_reg);
        end else begin
            lim = eff_w;
        end
    end

    assign can_send   = 32'(in_flight_reg) < 32'(eff_w);
    assign fill_more  = can_send && (32'(in_flight_reg) < 32'(count_reg));
    assign fill_last  = !((32'(in_flight_reg) + 32'd1 < 32'(eff_w)) &&
                          (32'(in_flight_reg) + 32'd1 < 32'(count_reg)));
    assign queue_full = count_reg == CNT_W'(QUEUE_DEPTH);
    assign is_ack     = op_reg == srsw_pkg::OP_ACK;
    assign rel_if     = found_pos_reg + IF_W'(1);
    assign rel_cnt    = CNT_W'(found_pos_reg) + CNT_W'(1);
    assign s_ready    = state_reg == ST_IDLE;

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        seq_next       = seq_reg;
        len_next       = len_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        in_flight_next = in_flight_reg;
        pos_next       = pos_reg;
        chk_valid_next = 1'b0;
        chk_pos_next   = chk_pos_reg;
        found_pos_next = found_pos_reg;
        fill_slot_next = fill_slot_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = slot_at(head_reg, count_reg);
        mem_wr_data    = '{seq: seq_reg, length: len_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = slot_at(head_reg, CNT_W'(pos_reg));
        out_push       = 1'b0;
        out_data       = '{status: 1'b0, seq: mem_rd_data.seq,
                           length: mem_rd_data.length, last: 1'b1};
        out_slot       = fill_slot_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next  = srsw_pkg::op_t'(s_operation);
                    seq_next = s_seq_number;
                    len_next = s_frame_length;
                    pos_next = '0;
                    case (srsw_pkg::op_t'(s_operation)) inside
                        srsw_pkg::OP_SEND: state_next = ST_SEND;
                        srsw_pkg::OP_ACK, srsw_pkg::OP_NAK, srsw_pkg::OP_TIMEOUT:
                            state_next = ST_SEARCH;
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SEND: begin
                if (!(queue_full || can_send) || out_free) begin
                    state_next = ST_IDLE;
                    if (queue_full) begin
                        // dropped send
                        out_push = 1'b1;
                        out_data = '{status: 1'b1, seq: '0, length: '0, last: 1'b1};
                        out_slot = '0;
                    end else begin
                        mem_wr_en  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (can_send) begin
                            out_push       = 1'b1;
                            out_data       = '{status: 1'b0, seq: seq_reg,
                                               length: len_reg, last: 1'b1};
                            out_slot       = slot_at(head_reg, count_reg);
                            in_flight_next = in_flight_reg + IF_W'(1);
                        end
                    end
                end
            end
            ST_SEARCH: begin
                // one read issued per cycle, compare in the next cycle
                if (chk_valid_reg && (mem_rd_data.seq == seq_reg)) begin
                    found_pos_next = chk_pos_reg;
                    state_next     = is_ack ? ST_ACK_UPD : ST_RETX;
                end else if (pos_reg < lim) begin
                    mem_rd_en      = 1'b1;
                    chk_valid_next = 1'b1;
                    chk_pos_next   = pos_reg;
                    pos_next       = pos_reg + IF_W'(1);
                end else if (!chk_valid_reg) begin
                    state_next = is_ack ? ST_FILL_RD : ST_IDLE;
                end
            end
            ST_RETX: begin
                if (out_free) begin
                    out_push   = 1'b1;
                    out_slot   = slot_at(head_reg, CNT_W'(found_pos_reg));
                    state_next = ST_IDLE;
                end
            end
            ST_ACK_UPD: begin
                head_next  = slot_at(head_reg, rel_cnt);
                count_next = count_reg - rel_cnt;
                if (in_flight_reg > rel_if) begin
                    in_flight_next = in_flight_reg - rel_if;
                end else begin
                    in_flight_next = '0;
                end
                state_next = ST_FILL_RD;
            end
            ST_FILL_RD: begin
                if (fill_more) begin
                    mem_rd_en      = 1'b1;
                    mem_rd_addr    = slot_at(head_reg, CNT_W'(in_flight_reg));
                    fill_slot_next = slot_at(head_reg, CNT_W'(in_flight_reg));
                    state_next     = ST_FILL_EMIT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_FILL_EMIT: begin
                if (out_free) begin
                    out_push       = 1'b1;
                    out_data.last  = fill_last;
                    in_flight_next = in_flight_reg + IF_W'(1);
                    state_next     = ST_FILL_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            in_flight_reg <= '0;
            wl_reg        <= srsw_pkg::WL_RESET;
            chk_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            in_flight_reg <= in_flight_next;
            chk_valid_reg <= chk_valid_next;
            if (cfg_wr_en) begin
                wl_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        seq_reg       <= seq_next;
        len_reg       <= len_next;
        pos_reg       <= pos_next;
        chk_pos_reg   <= chk_pos_next;
        found_pos_reg <= found_pos_next;
        fill_slot_reg <= fill_slot_next;
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= QUEUE_DEPTH)
        else $error("queue count beyond depth");

    a_inflight_le_count: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(in_flight_reg) <= 32'(count_reg))
        else $error("more frames in flight than queued");

    a_write_only_on_send: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_wr_en |-> (state_reg == ST_SEND) && !mem_rd_en)
        else $error("queue write outside a send");

    a_push_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_push |-> out_free)
        else $error("transmit request pushed into a busy output register");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg != ST_IDLE)
        else $error("accepted request not taken up");

endmodule

// File: rtl/selective_repeat_sender_window.sv
// selective repeat sender window: top level
// Each request is handled one at a time. An ack, nak or timeout searches the window
// through the queue memory's single read port, one entry per cycle, to find a match
// or give up; an ack then releases the entries up to a match and refills the window,
// reading each frame it moves in from the queue and pushing it to the result register
// before it returns to idle. Sends, retransmits and refills wait while the result
// register is held by m_ready. The default window is four. The queue memory needs
// no clearing after reset.
module selective_repeat_sender_window #(
    parameter int WINDOW      = 4,
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [1:0]                        s_operation,
    input  logic [srsw_pkg::SEQ_W-1:0]        s_seq_number,
    input  logic [srsw_pkg::LEN_W-1:0]        s_frame_length,
    input  logic                              cfg_wr_en,
    input  logic [srsw_pkg::WL_W-1:0]         cfg_wr_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_status,
    output logic [$clog2(QUEUE_DEPTH)-1:0]    m_tx_slot,
    output logic [srsw_pkg::SEQ_W-1:0]        m_tx_seq,
    output logic [srsw_pkg::LEN_W-1:0]        m_tx_length,
    output logic                              m_last
);

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int IF_W   = $clog2(WINDOW + 1);

    logic              mem_wr_en;
    logic [SLOT_W-1:0] mem_wr_addr;
    srsw_pkg::entry_t  mem_wr_data;
    logic              mem_rd_en;
    logic [SLOT_W-1:0] mem_rd_addr;
    srsw_pkg::entry_t  mem_rd_data;
    logic              out_free;
    logic              out_push;
    srsw_pkg::result_t out_data;
    logic [SLOT_W-1:0] out_slot;

    srsw_mem #(
        .DEPTH  (QUEUE_DEPTH),
        .ADDR_W (SLOT_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    srsw_out #(
        .SLOT_W (SLOT_W)
    ) u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (out_push),
        .push_data   (out_data),
        .push_slot   (out_slot),
        .free        (out_free),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_tx_slot   (m_tx_slot),
        .m_tx_seq    (m_tx_seq),
        .m_tx_length (m_tx_length),
        .m_last      (m_last)
    );

    srsw_ctrl #(
        .WINDOW      (WINDOW),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .SLOT_W      (SLOT_W),
        .CNT_W       (CNT_W),
        .IF_W        (IF_W)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_seq_number   (s_seq_number),
        .s_frame_length (s_frame_length),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data),
        .out_free       (out_free),
        .out_push       (out_push),
        .out_data       (out_data),
        .out_slot       (out_slot)
    );

endmodule
